[sv/kslk_pkg.sv]
package kslk_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD_REQ,
        ST_HEAD_CHK,
        ST_INS_REQ,
        ST_INS_CHK
    } state_t;

    // One buffered tuple.
    typedef struct packed {
        logic [31:0] ts;
        logic [31:0] payload;
        logic [31:0] delay;
    } entry_t;

endpackage

[sv/k_slack_reorder_buffer_unit.sv]
// A flush releases every buffered tuple in order; a tuple first releases the ripe head entries,
// then is sorted in from the tail past every later entry. The entry memory has a registered read
// port, so each release or sort step passes through a request state and a check state.
// Results appear one at a time; the receiver cannot stall, and a new word is taken only while idle.
// Reset (rst_n low, asynchronous) empties the buffer, clears local time and slack.
module k_slack_reorder_buffer_unit
    import kslk_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] in_ts,
    input  logic [31:0] in_payload,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    output logic [31:0] out_ts,
    output logic [31:0] out_payload,
    output logic [31:0] out_delay,
    output logic        forced,
    output logic        last
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    // Circular index arithmetic modulo the depth.
    function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(offs);
        if (sum >= (CW+1)'(BUFFER_DEPTH))
        begin
            sum = sum - (CW+1)'(BUFFER_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    entry_t          mem [BUFFER_DEPTH];
    entry_t          rd_reg;
    logic [AW-1:0]   raddr;
    logic            we;
    logic [AW-1:0]   waddr;
    entry_t          wdata;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [31:0]     lt_reg, lt_next;
    logic [15:0]     slack_reg;
    logic            flush_reg, flush_next;
    entry_t          new_reg, new_next;
    logic            pend_valid_reg, pend_valid_next;
    entry_t          pend_reg, pend_next;
    logic            pend_forced_reg, pend_forced_next;
    logic            out_valid_reg, out_valid_next;
    entry_t          out_reg, out_next;
    logic            out_forced_reg, out_forced_next;
    logic            out_last_reg, out_last_next;

    logic            ripe;
    logic            full;
    logic [31:0]     lt_arr;

    // Entry memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // Configuration register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slack_reg <= '0;
        end
        else if (cfg_valid)
        begin
            slack_reg <= cfg_data;
        end
    end

    assign ripe = ({1'b0, rd_reg.ts} + {17'b0, slack_reg}) <= {1'b0, lt_reg};
    assign full = (count_reg == CW'(BUFFER_DEPTH));
    assign lt_arr = (in_ts > lt_reg) ? in_ts : lt_reg;

    // Sequencer: releases from the head, then, for a tuple, sorts it in from the tail.
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        k_next           = k_reg;
        lt_next          = lt_reg;
        flush_next       = flush_reg;
        new_next         = new_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        pend_forced_next = pend_forced_reg;
        out_valid_next   = 1'b0;
        out_next         = out_reg;
        out_forced_next  = out_forced_reg;
        out_last_next    = out_last_reg;
        raddr            = head_reg;
        we               = 1'b0;
        waddr            = addr_add(head_reg, k_reg);
        wdata            = new_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    flush_next = mode;
                    if (!mode)
                    begin
                        lt_next     = lt_arr;
                        new_next.ts = in_ts;
                        new_next.payload = in_payload;
                        new_next.delay   = lt_arr - in_ts;
                    end
                    state_next = ST_HEAD_REQ;
                end
            end
            ST_HEAD_REQ:
            begin
                raddr      = head_reg;
                state_next = ST_HEAD_CHK;
            end
            ST_HEAD_CHK:
            begin
                if (count_reg != '0 && (flush_reg || ripe || full))
                begin
                    // Show the previous release; it is not the last one.
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_next        = pend_reg;
                        out_forced_next = pend_forced_reg;
                        out_last_next   = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_next        = rd_reg;
                    pend_forced_next = !flush_reg && !ripe;
                    head_next        = addr_add(head_reg, CW'(1));
                    count_next       = count_reg - CW'(1);
                    state_next       = ST_HEAD_REQ;
                end
                else
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_next        = pend_reg;
                        out_forced_next = pend_forced_reg;
                        out_last_next   = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    k_next          = count_reg;
                    state_next      = flush_reg ? ST_IDLE : ST_INS_REQ;
                end
            end
            ST_INS_REQ:
            begin
                raddr = addr_add(head_reg, k_reg - CW'(1));
                if (k_reg == '0)
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK:
            begin
                we = 1'b1;
                if (rd_reg.ts > new_reg.ts)
                begin
                    // Move the later entry one place towards the tail.
                    wdata      = rd_reg;
                    k_next     = k_reg - CW'(1);
                    state_next = ST_INS_REQ;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
            lt_reg         <= '0;
            flush_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            lt_reg         <= lt_next;
            flush_reg      <= flush_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        new_reg         <= new_next;
        pend_reg        <= pend_next;
        pend_forced_reg <= pend_forced_next;
        out_reg         <= out_next;
        out_forced_reg  <= out_forced_next;
        out_last_reg    <= out_last_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_ts      = out_reg.ts;
    assign out_payload = out_reg.payload;
    assign out_delay   = out_reg.delay;
    assign forced      = out_forced_reg;
    assign last        = out_last_reg;

endmodule

[sv/kslk_checker.sv]
module kslk_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cfg_valid,
    input logic cfg_ready,
    input logic out_valid
);

    // An accepted word always starts work.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    // Releases are never strobed back to back.
    a_out_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid)
        else $error("results on consecutive cycles");

    // Idle without a start stays idle.
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !busy)
        else $error("block became busy without a start");

    // Configuration writes are never held off.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

endmodule

bind k_slack_reorder_buffer_unit kslk_checker u_kslk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid)
);

[tb/k_slack_reorder_buffer_unit_tb.sv]
module k_slack_reorder_buffer_unit_tb;
    import kslk_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    // Quiet cycles before a slack write: a tuple that releases nothing may still be sorting.
    localparam int SETTLE      = 60;

    typedef enum logic [1:0] {
        WORD_TUPLE,
        WORD_FLUSH,
        WORD_SLACK
    } word_kind_t;

    typedef struct {
        word_kind_t  kind;
        logic [31:0] ts;
        logic [31:0] payload;
        logic [15:0] slack_val;
        int          idle_pct;
    } stim_word_t;

    typedef struct {
        logic [31:0] ts;
        logic [31:0] payload;
        logic [31:0] delay;
        logic        forced;
        logic        last;
    } release_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        mode = 1'b0;
    logic [31:0] in_ts = '0;
    logic [31:0] in_payload = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        out_valid;
    logic [31:0] out_ts;
    logic [31:0] out_payload;
    logic [31:0] out_delay;
    logic        forced;
    logic        last;

    stim_word_t  pending_words[$];
    release_t    expected_releases[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          quiet_cycles = 0;
    int          idle_pct = 0;
    int          tuples_sent = 0;
    int          flushes_sent = 0;
    int          releases_seen = 0;
    int          forced_seen = 0;
    stim_word_t  cur_word;

    // Local copy of the buffer state.
    logic [31:0] buf_ts[DEPTH];
    logic [31:0] buf_payload[DEPTH];
    logic [31:0] buf_delay[DEPTH];
    int          buf_count = 0;
    logic [31:0] model_time = '0;
    logic [15:0] model_slack = '0;

    k_slack_reorder_buffer_unit #(.BUFFER_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .in_ts(in_ts), .in_payload(in_payload), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data), .out_valid(out_valid),
        .out_ts(out_ts), .out_payload(out_payload), .out_delay(out_delay),
        .forced(forced), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Takes the head entry out of the buffer and queues it as an expected release.
    function automatic void release_head(input logic is_forced);
        release_t r;
        r.ts      = buf_ts[0];
        r.payload = buf_payload[0];
        r.delay   = buf_delay[0];
        r.forced  = is_forced;
        r.last    = 1'b0;
        expected_releases.push_back(r);
        for (int i = 1; i < buf_count; i++)
        begin
            buf_ts[i-1]      = buf_ts[i];
            buf_payload[i-1] = buf_payload[i];
            buf_delay[i-1]   = buf_delay[i];
        end
        buf_count--;
    endfunction

    // Works out the releases that one accepted word causes.
    function automatic void predict_releases(input stim_word_t w);
        int          before_n;
        int          pos;
        logic [31:0] delay;
        before_n = expected_releases.size();
        if (w.kind == WORD_FLUSH)
        begin
            while (buf_count > 0)
                release_head(1'b0);
        end
        else
        begin
            if (w.ts > model_time)
                model_time = w.ts;
            delay = model_time - w.ts;
            while (buf_count > 0 &&
                   ({1'b0, buf_ts[0]} + {17'd0, model_slack}) <= {1'b0, model_time})
                release_head(1'b0);
            if (buf_count >= DEPTH)
                release_head(1'b1);
            pos = buf_count;
            while (pos > 0 && buf_ts[pos-1] > w.ts)
                pos--;
            for (int i = buf_count; i > pos; i--)
            begin
                buf_ts[i]      = buf_ts[i-1];
                buf_payload[i] = buf_payload[i-1];
                buf_delay[i]   = buf_delay[i-1];
            end
            buf_ts[pos]      = w.ts;
            buf_payload[pos] = w.payload;
            buf_delay[pos]   = delay;
            buf_count++;
        end
        if (expected_releases.size() > before_n)
            expected_releases[expected_releases.size()-1].last = 1'b1;
    endfunction

    // Driver: presents words from the pending queue and writes slack only when idle.
    always @(posedge clk)
    begin
        logic nxt_start;
        logic nxt_cfg;
        nxt_start = start;
        nxt_cfg   = cfg_valid;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (start && !busy)
            begin
                predict_releases(cur_word);
                if (cur_word.kind == WORD_FLUSH)
                    flushes_sent++;
                else
                    tuples_sent++;
                nxt_start = 1'b0;
                quiet_cycles <= 0;
            end
            else if (!busy)
                quiet_cycles <= quiet_cycles + 1;
            else
                quiet_cycles <= 0;

            if (cfg_valid && cfg_ready)
            begin
                model_slack = cfg_data;
                idle_pct    = cur_word.idle_pct;
                nxt_cfg     = 1'b0;
                void'(pending_words.pop_front());
            end
            else if (!nxt_start && !nxt_cfg && pending_words.size() > 0)
            begin
                if (pending_words[0].kind == WORD_SLACK)
                begin
                    if (expected_releases.size() == 0 && !busy && !start &&
                        quiet_cycles >= SETTLE)
                    begin
                        cur_word = pending_words[0];
                        cfg_data <= pending_words[0].slack_val;
                        nxt_cfg  = 1'b1;
                    end
                end
                else if ($urandom_range(99) >= idle_pct)
                begin
                    cur_word = pending_words.pop_front();
                    mode       <= (cur_word.kind == WORD_FLUSH);
                    in_ts      <= cur_word.ts;
                    in_payload <= cur_word.payload;
                    nxt_start  = 1'b1;
                end
            end
        end
        start     <= nxt_start;
        cfg_valid <= nxt_cfg;
    end

    // Monitor: every strobed word is checked against the oldest expected release.
    always @(posedge clk)
    begin
        release_t e;
        if (rst_n && out_valid)
        begin
            releases_seen++;
            if (forced)
                forced_seen++;
            if (expected_releases.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected release: ts=%h payload=%h delay=%h", out_ts,
                             out_payload, out_delay);
            end
            else
            begin
                e = expected_releases.pop_front();
                if (out_ts !== e.ts || out_payload !== e.payload || out_delay !== e.delay ||
                    forced !== e.forced || last !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Release mismatch: expected ts=%h pl=%h dl=%h f=%b l=%b,",
                                 e.ts, e.payload, e.delay, e.forced, e.last);
                        $display("                  got      ts=%h pl=%h dl=%h f=%b l=%b",
                                 out_ts, out_payload, out_delay, forced, last);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_word(input word_kind_t k, input logic [31:0] ts,
                            input logic [31:0] pl, input logic [15:0] sl, input int pct);
        stim_word_t w;
        w.kind      = k;
        w.ts        = ts;
        w.payload   = pl;
        w.slack_val = sl;
        w.idle_pct  = pct;
        pending_words.push_back(w);
    endtask

    task automatic add_random_phase(input logic [15:0] sl, input int pct, input int n);
        logic [31:0] base;
        int          pick;
        base = 32'd5000 + $urandom_range(0, 1000);
        add_word(WORD_SLACK, '0, '0, sl, pct);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                add_word(WORD_FLUSH, $urandom, $urandom, '0, pct);
            else if (pick < 10)
            begin
                // Forward jump in time, releasing most of the buffer.
                base = base + $urandom_range(100, 3000);
                add_word(WORD_TUPLE, base, $urandom, '0, pct);
            end
            else
            begin
                base = base + $urandom_range(0, 6);
                add_word(WORD_TUPLE, base - $urandom_range(0, 40), $urandom, '0, pct);
            end
        end
        add_word(WORD_FLUSH, $urandom, $urandom, '0, pct);
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            buf_ts[i]      = '0;
            buf_payload[i] = '0;
            buf_delay[i]   = '0;
        end

        // Short directed opening with zero slack, then slack 50: immediate release, ties, flushes.
        add_word(WORD_SLACK, '0, '0, 16'd0, 0);
        add_word(WORD_TUPLE, 32'd100, 32'h0000_0001, '0, 0);
        add_word(WORD_TUPLE, 32'd0, 32'h0000_0000, '0, 0);
        add_word(WORD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 0);
        add_word(WORD_FLUSH, 32'h0, 32'h0, '0, 0);
        add_word(WORD_SLACK, '0, '0, 16'd50, 0);
        add_word(WORD_TUPLE, 32'd200, 32'hA5A5_A5A5, '0, 0);
        add_word(WORD_TUPLE, 32'd200, 32'h5A5A_5A5A, '0, 0);
        add_word(WORD_TUPLE, 32'd180, 32'h1234_5678, '0, 0);
        add_word(WORD_TUPLE, 32'd250, 32'h8765_4321, '0, 0);
        add_word(WORD_FLUSH, '0, '0, '0, 0);

        // Random phases: sender idling at 26, then 75, then none; slack extremes included.
        add_random_phase(16'd20, 26, 26);
        add_random_phase(16'd65535, 75, 26);
        add_random_phase(16'd0, 0, 12);
        add_random_phase(16'd300, 0, 10);

        // Extreme timestamps last, since local time never falls again afterwards.
        add_word(WORD_SLACK, '0, '0, 16'd65535, 0);
        for (int i = 0; i < 18; i++)
            add_word(WORD_TUPLE, 32'hFFFF_FFF0 + (i % 3), $urandom, '0, 0);
        add_word(WORD_TUPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 0);
        add_word(WORD_FLUSH, '0, '0, '0, 0);
        add_word(WORD_SLACK, '0, '0, 16'd0, 0);
        add_word(WORD_TUPLE, 32'hFFFF_FFFF, 32'h0, '0, 0);
        add_word(WORD_TUPLE, 32'hFFFF_FFFF, 32'h1, '0, 0);
        add_word(WORD_FLUSH, '0, '0, '0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || start || cfg_valid || expected_releases.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d tuples and %0d flushes; checked %0d releases, %0d of them forced.",
                 tuples_sent, flushes_sent, releases_seen, forced_seen);
        if (mismatches == 0 && expected_releases.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
